@@ rtl/srmt_pkg.sv @@
// shared types and codes for the sorted ring membership table
package srmt_pkg;

	localparam int ID_W = 16;

	// action codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_DUP     = 2'd1;
	localparam logic [1:0] STAT_MISSING = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RD_PRED,
		ST_RD_SUCC,
		ST_WT_SUCC,
		ST_SHIFT,
		ST_PUT,
		ST_DONE
	} state_t;

	// sequencer handshake toward the top level
	typedef struct packed {
		logic idle;
		logic done;
	} seq_status_t;

	// one finished result word
	typedef struct packed {
		logic [1:0]      status;
		logic [1:0]      nbr_count;
		logic [ID_W-1:0] first;
		logic [ID_W-1:0] second;
		logic [6:0]      count;
	} result_t;

endpackage

@@ rtl/srmt_ram.sv @@
// generic simple dual port ram with registered read
module srmt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/srmt_seq.sv @@
// search, neighbour fetch and shift sequencer around the id memory
module srmt_seq #(
	parameter int MAX_MEMBERS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  action,
	input  logic [srmt_pkg::ID_W-1:0]   member_id,
	input  logic                        res_ready,
	output srmt_pkg::seq_status_t       seq_status,
	output srmt_pkg::result_t           result
);

	localparam int AW = $clog2(MAX_MEMBERS);
	localparam int CW = $clog2(MAX_MEMBERS + 1);
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_MEMBERS);

	srmt_pkg::state_t state_q, state_d;

	logic [1:0]                act_q;
	logic [srmt_pkg::ID_W-1:0] id_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	logic                      chk_s1;
	logic [CW-1:0]             chk_idx_s1;
	logic                      found_q;
	logic [CW-1:0]             pos_q;
	logic [AW-1:0]             pa_q, sa_q;
	logic [1:0]                nc_q;
	logic [1:0]                status_q;
	logic [srmt_pkg::ID_W-1:0] first_q, second_q;
	logic                      do_ins_q, do_rem_q;
	logic [AW-1:0]             sh_idx_q;
	logic [CW-1:0]             left_q;
	logic                      wr_pend_s1;
	logic [AW-1:0]             wr_addr_s1;

	// ram ports
	logic                      we;
	logic [AW-1:0]             wr_addr, rd_addr;
	logic [srmt_pkg::ID_W-1:0] wr_data, rd_data;

	// scan compare
	logic hit_eq, hit_gt, scan_none, scan_done, scan_issue;

	// decision
	logic [1:0]    dc_status;
	logic          dc_nbr, dc_ins, dc_rem;
	logic [CW-1:0] dc_n;
	logic [1:0]    dc_nc;
	logic [AW-1:0] dc_pred, dc_succ, dc_sh_idx;
	logic [CW-1:0] dc_left;

	srmt_ram #(
		.WIDTH(srmt_pkg::ID_W),
		.DEPTH(MAX_MEMBERS)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign hit_eq     = chk_s1 && (rd_data == id_q);
	assign hit_gt     = chk_s1 && (rd_data > id_q);
	assign scan_none  = !chk_s1 && (idx_q == count_q);
	assign scan_done  = hit_eq || hit_gt || scan_none;
	assign scan_issue = (idx_q != count_q) && !scan_done;

	always_comb begin
		dc_status = srmt_pkg::STAT_OK;
		dc_nbr    = 1'b0;
		dc_ins    = 1'b0;
		dc_rem    = 1'b0;
		dc_n      = count_q;
		dc_pred   = (pos_q == '0) ? AW'(count_q - ONE_C) : AW'(pos_q - ONE_C);
		dc_succ   = AW'(pos_q);
		if (found_q) begin
			dc_nbr = 1'b1;
			dc_rem = (act_q == srmt_pkg::ACT_REMOVE);
			if (act_q == srmt_pkg::ACT_INSERT) begin
				dc_status = srmt_pkg::STAT_DUP;
			end
			dc_succ = (CW'(pos_q + ONE_C) == count_q) ? '0 : AW'(pos_q + ONE_C);
		end else if (act_q == srmt_pkg::ACT_INSERT) begin
			if (count_q >= MAX_C) begin
				dc_status = srmt_pkg::STAT_FULL;
			end else begin
				dc_nbr  = 1'b1;
				dc_ins  = 1'b1;
				dc_n    = CW'(count_q + ONE_C);
				dc_succ = (pos_q == count_q) ? '0 : AW'(pos_q);
			end
		end else begin
			dc_status = srmt_pkg::STAT_MISSING;
		end
		if (!dc_nbr || dc_n < CW'(2)) begin
			dc_nc = 2'd0;
		end else if (dc_n == CW'(2)) begin
			dc_nc = 2'd1;
		end else begin
			dc_nc = 2'd2;
		end
		// insert moves entries up from the top, remove moves them down
		if (dc_ins) begin
			dc_sh_idx = AW'(count_q - ONE_C);
			dc_left   = CW'(count_q - pos_q);
		end else begin
			dc_sh_idx = AW'(pos_q + ONE_C);
			dc_left   = CW'(count_q - ONE_C - pos_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			srmt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = srmt_pkg::ST_SCAN;
				end
			end
			srmt_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = srmt_pkg::ST_DECIDE;
				end
			end
			srmt_pkg::ST_DECIDE: begin
				if (dc_nc != 2'd0) begin
					state_d = srmt_pkg::ST_RD_PRED;
				end else if (dc_ins || dc_rem) begin
					state_d = srmt_pkg::ST_SHIFT;
				end else begin
					state_d = srmt_pkg::ST_DONE;
				end
			end
			srmt_pkg::ST_RD_PRED: begin
				state_d = srmt_pkg::ST_RD_SUCC;
			end
			srmt_pkg::ST_RD_SUCC: begin
				if (nc_q == 2'd2) begin
					state_d = srmt_pkg::ST_WT_SUCC;
				end else if (do_ins_q || do_rem_q) begin
					state_d = srmt_pkg::ST_SHIFT;
				end else begin
					state_d = srmt_pkg::ST_DONE;
				end
			end
			srmt_pkg::ST_WT_SUCC: begin
				if (do_ins_q || do_rem_q) begin
					state_d = srmt_pkg::ST_SHIFT;
				end else begin
					state_d = srmt_pkg::ST_DONE;
				end
			end
			srmt_pkg::ST_SHIFT: begin
				if (left_q == '0) begin
					state_d = do_ins_q ? srmt_pkg::ST_PUT : srmt_pkg::ST_DONE;
				end
			end
			srmt_pkg::ST_PUT: begin
				state_d = srmt_pkg::ST_DONE;
			end
			srmt_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = srmt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srmt_pkg::ST_IDLE;
			end
		endcase
	end

	// memory port drive and handshake outputs
	always_comb begin
		rd_addr         = idx_q[AW-1:0];
		we              = 1'b0;
		wr_addr         = wr_addr_s1;
		wr_data         = rd_data;
		seq_status.idle = 1'b0;
		seq_status.done = 1'b0;
		case (state_q)
			srmt_pkg::ST_IDLE: begin
				seq_status.idle = 1'b1;
			end
			srmt_pkg::ST_SCAN: begin
				rd_addr = idx_q[AW-1:0];
			end
			srmt_pkg::ST_RD_PRED: begin
				rd_addr = pa_q;
			end
			srmt_pkg::ST_RD_SUCC: begin
				rd_addr = sa_q;
			end
			srmt_pkg::ST_SHIFT: begin
				rd_addr = sh_idx_q;
				we      = wr_pend_s1;
			end
			srmt_pkg::ST_PUT: begin
				we      = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = id_q;
			end
			srmt_pkg::ST_DONE: begin
				seq_status.done = 1'b1;
			end
			default: begin
				rd_addr = idx_q[AW-1:0];
			end
		endcase
	end

	assign result.status    = status_q;
	assign result.nbr_count = nc_q;
	assign result.first     = first_q;
	assign result.second    = second_q;
	assign result.count     = 7'(count_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= srmt_pkg::ST_IDLE;
			count_q    <= '0;
			chk_s1     <= 1'b0;
			wr_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_s1     <= (state_q == srmt_pkg::ST_SCAN) && scan_issue;
			wr_pend_s1 <= (state_q == srmt_pkg::ST_SHIFT) && (left_q != '0);
			if (state_q == srmt_pkg::ST_PUT) begin
				count_q <= CW'(count_q + ONE_C);
			end else if (state_q == srmt_pkg::ST_SHIFT && left_q == '0 && do_rem_q) begin
				count_q <= CW'(count_q - ONE_C);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		chk_idx_s1 <= idx_q;
		case (state_q)
			srmt_pkg::ST_IDLE: begin
				act_q <= action;
				id_q  <= member_id;
				idx_q <= '0;
			end
			srmt_pkg::ST_SCAN: begin
				if (scan_issue) begin
					idx_q <= CW'(idx_q + ONE_C);
				end
				found_q <= hit_eq;
				pos_q   <= (hit_eq || hit_gt) ? chk_idx_s1 : count_q;
			end
			srmt_pkg::ST_DECIDE: begin
				status_q <= dc_status;
				nc_q     <= dc_nc;
				pa_q     <= dc_pred;
				sa_q     <= dc_succ;
				do_ins_q <= dc_ins;
				do_rem_q <= dc_rem;
				sh_idx_q <= dc_sh_idx;
				left_q   <= dc_left;
				first_q  <= '0;
				second_q <= '0;
			end
			srmt_pkg::ST_RD_SUCC: begin
				first_q <= rd_data;
			end
			srmt_pkg::ST_WT_SUCC: begin
				second_q <= rd_data;
			end
			srmt_pkg::ST_SHIFT: begin
				if (left_q != '0) begin
					left_q     <= CW'(left_q - ONE_C);
					sh_idx_q   <= do_ins_q ? AW'(sh_idx_q - 1'b1) : AW'(sh_idx_q + 1'b1);
					wr_addr_s1 <= do_ins_q ? AW'(sh_idx_q + 1'b1) : AW'(sh_idx_q - 1'b1);
				end
			end
			default: begin
				left_q <= left_q;
			end
		endcase
	end

endmodule

@@ rtl/sorted_ring_membership_table.sv @@
// top level of the sorted ring membership table
//
// keeps up to MAX_MEMBERS distinct 16-bit member ids in ascending order,
// seen as a ring, in one simple dual port ram
// input channel (in_valid/in_ready): one word is action and member_id;
// insert, remove or query one id
// output channel (out_valid/out_ready): one result word per input word with
// status, neighbour_count, first_neighbour, second_neighbour, member_count
// one word is worked at a time; in_ready is high while the sequencer idles
// a linear search reads one entry per cycle up to the hit or insertion
// point, then up to two neighbour reads, then, for an insert or removal,
// the entries above that point move one place per cycle; the single ram
// read port sets this pace
// the finished result sits in an output register; while the receiver
// stalls, the sequencer holds its result and a new word is taken as soon
// as that result has moved into the output register
// reset empties the table (count to zero); ram contents are not cleared,
// entries beyond the count are never used
module sorted_ring_membership_table #(
	parameter int MAX_MEMBERS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                action,
	input  logic [srmt_pkg::ID_W-1:0] member_id,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [1:0]                neighbour_count,
	output logic [srmt_pkg::ID_W-1:0] first_neighbour,
	output logic [srmt_pkg::ID_W-1:0] second_neighbour,
	output logic [6:0]                member_count
);

	srmt_pkg::seq_status_t seq_status;
	srmt_pkg::result_t     seq_result;
	srmt_pkg::result_t     out_q;
	logic                  out_valid_q;
	logic                  res_ready;
	logic                  start;

	// output register is free when empty or being emptied this cycle
	assign res_ready = !out_valid_q || out_ready;
	assign in_ready  = seq_status.idle;
	assign start     = in_valid && seq_status.idle;

	srmt_seq #(
		.MAX_MEMBERS(MAX_MEMBERS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (action),
		.member_id  (member_id),
		.res_ready  (res_ready),
		.seq_status (seq_status),
		.result     (seq_result)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_status.done && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (seq_status.done && res_ready) begin
			out_q <= seq_result;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_q.status;
	assign neighbour_count  = out_q.nbr_count;
	assign first_neighbour  = out_q.first;
	assign second_neighbour = out_q.second;
	assign member_count     = out_q.count;

endmodule

@@ tb/srmt_ring_checker.sv @@
// checker for the sorted ring membership table: tracks the members, predicts and compares each word
module srmt_ring_checker #(
	parameter int MAX_MEMBERS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [1:0]                action,
	input  logic [srmt_pkg::ID_W-1:0] member_id,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [1:0]                status,
	input  logic [1:0]                neighbour_count,
	input  logic [srmt_pkg::ID_W-1:0] first_neighbour,
	input  logic [srmt_pkg::ID_W-1:0] second_neighbour,
	input  logic [6:0]                member_count,
	output int                        errors,
	output int                        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_W = srmt_pkg::ID_W;

	bit [ID_W-1:0]     roster[$];
	srmt_pkg::result_t awaited[$];

	initial begin
		errors = 0;
		outstanding = 0;
	end

	// ring neighbours of the member at position p in the current roster
	function automatic srmt_pkg::result_t ring_of(int p, srmt_pkg::result_t r);
		int n;
		n = roster.size();
		if (n == 2) begin
			r.nbr_count = 2'd1;
			r.first = roster[p == 0 ? 1 : 0];
		end else if (n >= 3) begin
			r.nbr_count = 2'd2;
			r.first = roster[p == 0 ? n - 1 : p - 1];
			r.second = roster[p + 1 == n ? 0 : p + 1];
		end
		return r;
	endfunction

	// applies one word to the roster and returns the result word it should give
	function automatic srmt_pkg::result_t apply_word(logic [1:0] act, logic [ID_W-1:0] id);
		srmt_pkg::result_t r;
		int at;
		bit hit;
		r = '0;
		at = 0;
		while (at < roster.size() && roster[at] < id)
			at++;
		hit = (at < roster.size()) && (roster[at] == id);
		case (act)
		srmt_pkg::ACT_INSERT: begin
			if (hit) begin
				r.status = srmt_pkg::STAT_DUP;
				r = ring_of(at, r);
			end else if (roster.size() >= MAX_MEMBERS) begin
				r.status = srmt_pkg::STAT_FULL;
			end else begin
				roster.insert(at, id);
				r.status = srmt_pkg::STAT_OK;
				r = ring_of(at, r);
			end
		end
		srmt_pkg::ACT_REMOVE: begin
			if (!hit) begin
				r.status = srmt_pkg::STAT_MISSING;
			end else begin
				r = ring_of(at, r);
				roster.delete(at);
			end
		end
		default: begin
			if (!hit)
				r.status = srmt_pkg::STAT_MISSING;
			else
				r = ring_of(at, r);
		end
		endcase
		r.count = 7'(roster.size());
		return r;
	endfunction

	task automatic flag(string what, int got, int want);
		errors++;
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		srmt_pkg::result_t want;
		if (!arst_n) begin
			roster.delete();
			awaited.delete();
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					flag("word with nothing outstanding, status", status, 0);
				end else begin
					want = awaited.pop_front();
					if (status != want.status)
						flag("status", status, want.status);
					if (neighbour_count != want.nbr_count)
						flag("neighbour_count", neighbour_count, want.nbr_count);
					if (first_neighbour != want.first)
						flag("first_neighbour", first_neighbour, want.first);
					if (second_neighbour != want.second)
						flag("second_neighbour", second_neighbour, want.second);
					if (member_count != want.count)
						flag("member_count", member_count, want.count);
				end
			end
			if (in_valid && in_ready)
				awaited.push_back(apply_word(action, member_id));
			outstanding = awaited.size();
		end
	end

endmodule

@@ tb/sorted_ring_membership_table_tb.sv @@
// testbench top for the sorted ring membership table: stimulus, flow control and verdict
module sorted_ring_membership_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_W = srmt_pkg::ID_W;
	localparam int MAX_MEMBERS = 64;
	// action code 3 is unused and must behave as a query
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int POOL_DEPTH = 72;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [1:0]      action;
	logic [ID_W-1:0] member_id;
	logic            out_valid;
	logic            out_ready;
	logic [1:0]      status;
	logic [1:0]      neighbour_count;
	logic [ID_W-1:0] first_neighbour;
	logic [ID_W-1:0] second_neighbour;
	logic [6:0]      member_count;

	int errors;
	int outstanding;

	// quiet: no idling on either side; hold_req: ask the receiver for one long stall
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	// ids drawn by the random phases, so that most words hit existing members
	bit [ID_W-1:0] pool[POOL_DEPTH];
	int pool_n;

	sorted_ring_membership_table #(
		.MAX_MEMBERS(MAX_MEMBERS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.member_id(member_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.neighbour_count(neighbour_count),
		.first_neighbour(first_neighbour),
		.second_neighbour(second_neighbour),
		.member_count(member_count)
	);

	srmt_ring_checker #(
		.MAX_MEMBERS(MAX_MEMBERS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.member_id(member_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.neighbour_count(neighbour_count),
		.first_neighbour(first_neighbour),
		.second_neighbour(second_neighbour),
		.member_count(member_count),
		.errors(errors),
		.outstanding(outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// offers one word: optional gap first, then holds valid and payload until taken
	// entered and left at a falling edge
	task automatic offer(logic [1:0] act, logic [ID_W-1:0] id);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		member_id <= id;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// stop offering until every result word has come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// fresh random ids; the first n entries are used
	task automatic fill_pool(int n);
		int k;
		for (k = 0; k < POOL_DEPTH; k++)
			pool[k] = ID_W'($urandom);
		pool_n = n;
	endtask

	// random words with the given mix; a tenth of the ids are fully random noise
	task automatic run_phase(int items, int ins_pct, int rem_pct);
		int k;
		int roll;
		logic [1:0] act;
		logic [ID_W-1:0] id;
		for (k = 0; k < items; k++) begin
			// a stretch without idling at the start of every block of 120 words
			quiet = (k % 120) < 25;
			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				act = srmt_pkg::ACT_INSERT;
			else if (roll < ins_pct + rem_pct)
				act = srmt_pkg::ACT_REMOVE;
			else if (roll < 97)
				act = srmt_pkg::ACT_QUERY;
			else
				act = ACT_SPARE;
			if ($urandom_range(0, 9) == 0)
				id = ID_W'($urandom);
			else
				id = pool[$urandom_range(0, pool_n - 1)];
			offer(act, id);
		end
		quiet = 1'b0;
		settle();
	endtask

	// receiver: draws a stall before every result word, or one long hold on request
	initial begin : drain_side
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 10);
			if (hold_req) begin
				// long hold so the output register and the sequencer both fill up
				hold_req = 1'b0;
				stall = 300;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = srmt_pkg::ACT_QUERY;
		member_id = '0;
		out_ready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: lookups of absent ids
		offer(srmt_pkg::ACT_QUERY, 16'h0000);
		offer(srmt_pkg::ACT_REMOVE, 16'hFFFF);
		// single member has no neighbours
		offer(srmt_pkg::ACT_INSERT, 16'h8000);
		offer(srmt_pkg::ACT_QUERY, 16'h8000);
		// two members: unsigned order puts 7fff below 8000, one neighbour
		offer(srmt_pkg::ACT_INSERT, 16'h7FFF);
		// duplicate insert reports the existing member's neighbours
		offer(srmt_pkg::ACT_INSERT, 16'h8000);
		offer(srmt_pkg::ACT_INSERT, 16'hFFFF);
		offer(srmt_pkg::ACT_INSERT, 16'h0000);
		// wrap around the ring at both ends
		offer(srmt_pkg::ACT_QUERY, 16'h0000);
		offer(srmt_pkg::ACT_QUERY, 16'hFFFF);
		// unused action code as a query, hit and miss
		offer(ACT_SPARE, 16'h7FFF);
		offer(ACT_SPARE, 16'h1234);
		// removal reports the neighbours held before it
		offer(srmt_pkg::ACT_REMOVE, 16'h7FFF);
		offer(srmt_pkg::ACT_REMOVE, 16'h7FFF);
		offer(srmt_pkg::ACT_QUERY, 16'h5555);
		offer(srmt_pkg::ACT_REMOVE, 16'h8000);
		offer(srmt_pkg::ACT_REMOVE, 16'hFFFF);
		offer(srmt_pkg::ACT_REMOVE, 16'h0000);
		offer(srmt_pkg::ACT_QUERY, 16'hAAAA);
		settle();

		// tiny pool of five ids: lots of traffic at small member counts
		fill_pool(5);
		run_phase(250, 40, 35);

		// big pool with heavy inserts: fills the table up to full;
		// the receiver holds off at the start while words keep coming
		fill_pool(POOL_DEPTH);
		hold_req = 1'b1;
		run_phase(300, 75, 8);
		run_phase(250, 40, 30);
		// drain most of the table again
		run_phase(300, 10, 65);

		fill_pool(3);
		run_phase(200, 45, 35);

		fill_pool(POOL_DEPTH);
		run_phase(250, 75, 8);
		run_phase(200, 10, 70);

		// every word is back; allow the block to go quiet
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("sorted_ring_membership_table regression: pass");
		else
			$display("sorted_ring_membership_table regression: fail");
		$finish;
	end

	// hang guard, several times the slowest correct run
	initial begin
		#20_000_000;
		$display("sorted_ring_membership_table regression: fail");
		$finish;
	end

endmodule
